// ===== design/sslim_pkg.sv =====
// ----------------------------------------------------------------------------
// sslim_pkg
// Shared types and constants of the two-axis servo slew limiter.
// ----------------------------------------------------------------------------
package sslim_pkg;

  // angle range of one servo axis
  localparam int unsigned AngleW    = 8;
  localparam int unsigned ValueW    = 10;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam logic [AngleW-1:0] FullScale   = 8'd180;
  localparam logic [AngleW-1:0] CenterAngle = 8'd90;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_PAN_REL  = 3'd1,
    CMD_TILT_REL = 3'd2,
    CMD_PAN_ABS  = 3'd3,
    CMD_TILT_ABS = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAN_MIN     = 3'd0,
    REG_PAN_MAX     = 3'd1,
    REG_TILT_MIN    = 3'd2,
    REG_TILT_MAX    = 3'd3,
    REG_SLEW_STEP   = 3'd4,
    REG_PAN_INVERT  = 3'd5,
    REG_TILT_INVERT = 3'd6
  } reg_idx_e;

  // live configuration, limits already held to full scale
  typedef struct packed {
    logic [AngleW-1:0] pan_min;
    logic [AngleW-1:0] pan_max;
    logic [AngleW-1:0] tilt_min;
    logic [AngleW-1:0] tilt_max;
    logic [AngleW-1:0] slew_step;
    logic              pan_invert;
    logic              tilt_invert;
  } cfg_t;

  // per-axis update strobes
  typedef struct packed {
    logic step;
    logic set_rel;
    logic set_abs;
  } axis_ctl_t;

endpackage

// ===== design/two_axis_servo_slew_limiter_core.sv =====
// ----------------------------------------------------------------------------
// two_axis_servo_slew_limiter_core
// Pan and tilt servo controller with clamped targets and alternating slew.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the result side is not stalled; the input
//   register and the result register each hold one word, and one pass of axis
//   logic sits between them
// reset: positions and targets at 90 degrees, pan moves first,
//   limits 0 to 180, slew step 2, no inversion
module two_axis_servo_slew_limiter_core
  import sslim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AngleW-1:0]  cfg_data_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // value[9:0], zero fill
  input  logic [CmdW-1:0]    s_axis_tuser,   // command[2:0]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // pan_angle, tilt_angle, pan_drive, tilt_drive, pan_goal, tilt_goal,
  // pan_moved, tilt_moved, zero fill
  output logic [55:0]        m_axis_tdata
);

  cfg_t                     cfg;
  logic                     in_vld_q, in_vld_d;
  logic [CmdW-1:0]          in_cmd_q;
  logic signed [ValueW-1:0] in_val_q;
  logic                     out_vld_q, out_vld_d;
  logic [55:0]              out_data_q, out_data_d;
  logic                     turn_q, turn_d;
  logic                     adv, s_acc, m_acc;
  axis_ctl_t                pan_ctl, tilt_ctl;
  logic                     pan_need, tilt_need;
  logic                     is_tick;
  logic [AngleW-1:0]        pan_pos, tilt_pos, pan_tgt, tilt_tgt;
  logic [AngleW-1:0]        pan_drv, tilt_drv;
  logic                     pan_moved, tilt_moved;

  sslim_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake and stage advance
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign in_vld_d      = s_acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d     = adv ? 1'b1 : (m_acc ? 1'b0 : out_vld_q);

  // command decode and move arbitration
  always_comb begin
    pan_ctl  = '0;
    tilt_ctl = '0;
    is_tick  = 1'b0;
    unique case (in_cmd_q)
      CMD_TICK:     is_tick          = 1'b1;
      CMD_PAN_REL:  pan_ctl.set_rel  = adv;
      CMD_TILT_REL: tilt_ctl.set_rel = adv;
      CMD_PAN_ABS:  pan_ctl.set_abs  = adv;
      CMD_TILT_ABS: tilt_ctl.set_abs = adv;
      default:      is_tick          = 1'b0;
    endcase
    pan_ctl.step  = adv && is_tick && pan_need  && (!tilt_need || turn_q);
    tilt_ctl.step = adv && is_tick && tilt_need && (!pan_need  || !turn_q);
  end

  // alternate only when both axes are pending
  assign turn_d = (adv && is_tick && pan_need && tilt_need) ? !turn_q : turn_q;

  sslim_axis u_pan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (pan_ctl),
    .value_i   (in_val_q),
    .lo_i      (cfg.pan_min),
    .hi_i      (cfg.pan_max),
    .slew_i    (cfg.slew_step),
    .need_o    (pan_need),
    .pos_nxt_o (pan_pos),
    .tgt_nxt_o (pan_tgt),
    .moved_o   (pan_moved)
  );

  sslim_axis u_tilt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tilt_ctl),
    .value_i   (in_val_q),
    .lo_i      (cfg.tilt_min),
    .hi_i      (cfg.tilt_max),
    .slew_i    (cfg.slew_step),
    .need_o    (tilt_need),
    .pos_nxt_o (tilt_pos),
    .tgt_nxt_o (tilt_tgt),
    .moved_o   (tilt_moved)
  );

  // drive angles, mirrored when inverted
  assign pan_drv  = cfg.pan_invert  ? (FullScale - pan_pos)  : pan_pos;
  assign tilt_drv = cfg.tilt_invert ? (FullScale - tilt_pos) : tilt_pos;

  // result word
  assign out_data_d = {6'b0, tilt_moved, pan_moved, tilt_tgt, pan_tgt,
                       tilt_drv, pan_drv, tilt_pos, pan_pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      turn_q    <= 1'b1;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      turn_q    <= turn_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_cmd_q <= s_axis_tuser;
      in_val_q <= s_axis_tdata[ValueW-1:0];
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/sslim_cfg.sv =====
// ----------------------------------------------------------------------------
// sslim_cfg
// Configuration register bank; angle limits are held to full scale on write.
// ----------------------------------------------------------------------------
module sslim_cfg
  import sslim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AngleW-1:0]  cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t              cfg_q;
  cfg_t              cfg_d;
  logic [AngleW-1:0] lim_data;

  // limits above full scale act as full scale
  assign lim_data = (cfg_data_i > FullScale) ? FullScale : cfg_data_i;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAN_MIN:     cfg_d.pan_min     = lim_data;
        REG_PAN_MAX:     cfg_d.pan_max     = lim_data;
        REG_TILT_MIN:    cfg_d.tilt_min    = lim_data;
        REG_TILT_MAX:    cfg_d.tilt_max    = lim_data;
        REG_SLEW_STEP:   cfg_d.slew_step   = cfg_data_i;
        REG_PAN_INVERT:  cfg_d.pan_invert  = cfg_data_i[0];
        REG_TILT_INVERT: cfg_d.tilt_invert = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_min     <= '0;
      cfg_q.pan_max     <= FullScale;
      cfg_q.tilt_min    <= '0;
      cfg_q.tilt_max    <= FullScale;
      cfg_q.slew_step   <= 8'd2;
      cfg_q.pan_invert  <= 1'b0;
      cfg_q.tilt_invert <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/sslim_axis.sv =====
// ----------------------------------------------------------------------------
// sslim_axis
// One servo axis: target register with clamped updates and a position
// register that slews toward the target.
// ----------------------------------------------------------------------------
module sslim_axis
  import sslim_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  axis_ctl_t                ctl_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [AngleW-1:0]        lo_i,
  input  logic [AngleW-1:0]        hi_i,
  input  logic [AngleW-1:0]        slew_i,
  output logic                     need_o,
  output logic [AngleW-1:0]        pos_nxt_o,
  output logic [AngleW-1:0]        tgt_nxt_o,
  output logic                     moved_o
);

  localparam int unsigned ReqW  = ValueW + 1;
  localparam int unsigned DiffW = AngleW + 2;

  logic [AngleW-1:0]       pos_q, pos_d;
  logic [AngleW-1:0]       tgt_q, tgt_d;
  logic signed [ReqW-1:0]  req;
  logic signed [ReqW-1:0]  lo_s, hi_s;
  logic [AngleW-1:0]       clamped;
  logic signed [DiffW-1:0] diff, slew_s, delta;
  logic signed [DiffW-1:0] pos_sum;

  assign need_o = (pos_q != tgt_q);

  // requested target, relative or absolute
  assign req  = ctl_i.set_rel
              ? $signed({{(ReqW-AngleW){1'b0}}, tgt_q}) + ReqW'(value_i)
              : ReqW'(value_i);
  assign lo_s = $signed({{(ReqW-AngleW){1'b0}}, lo_i});
  assign hi_s = $signed({{(ReqW-AngleW){1'b0}}, hi_i});

  // clamp, low bound tested first
  always_comb begin
    priority if (req < lo_s) begin
      clamped = lo_i;
    end else if (req > hi_s) begin
      clamped = hi_i;
    end else begin
      clamped = req[AngleW-1:0];
    end
  end

  // step toward the target by at most the slew step
  assign diff   = $signed({2'b00, tgt_q}) - $signed({2'b00, pos_q});
  assign slew_s = $signed({2'b00, slew_i});
  always_comb begin
    priority if (diff < -slew_s) begin
      delta = -slew_s;
    end else if (diff > slew_s) begin
      delta = slew_s;
    end else begin
      delta = diff;
    end
  end
  assign pos_sum = $signed({2'b00, pos_q}) + delta;

  // next state
  always_comb begin
    pos_d = pos_q;
    tgt_d = tgt_q;
    if (ctl_i.step) begin
      pos_d = pos_sum[AngleW-1:0];
    end
    if (ctl_i.set_rel || ctl_i.set_abs) begin
      tgt_d = clamped;
    end
  end

  assign moved_o   = ctl_i.step && (pos_d != pos_q);
  assign pos_nxt_o = pos_d;
  assign tgt_nxt_o = tgt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= CenterAngle;
      tgt_q <= CenterAngle;
    end else begin
      pos_q <= pos_d;
      tgt_q <= tgt_d;
    end
  end

endmodule

// ===== bench/servo_slew_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_slew_checker
// Watches the configuration port and both streams of the servo slew limiter,
// keeps its own copy of the axis state, works out the pose that each input
// word should produce and compares it, field by field, with the result words.
// ----------------------------------------------------------------------------
module servo_slew_checker
  import sslim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AngleW-1:0]  cfg_data_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // value[9:0], zero fill
  input  logic [CmdW-1:0]    s_axis_tuser,   // command[2:0]
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // pan_angle, tilt_angle, pan_drive, tilt_drive, pan_goal, tilt_goal,
  // pan_moved, tilt_moved, zero fill
  input  logic [55:0]        m_axis_tdata,
  output int                 error_count,
  output int                 pending_count
);

  // one result word, last field in the lowest bits
  typedef struct packed {
    logic              tilt_moved;
    logic              pan_moved;
    logic [AngleW-1:0] tilt_goal;
    logic [AngleW-1:0] pan_goal;
    logic [AngleW-1:0] tilt_drive;
    logic [AngleW-1:0] pan_drive;
    logic [AngleW-1:0] tilt_angle;
    logic [AngleW-1:0] pan_angle;
  } servo_pose_t;

  // register copy
  logic [AngleW-1:0] pan_lo_reg, pan_hi_reg, tilt_lo_reg, tilt_hi_reg, slew_reg;
  logic              pan_mirror, tilt_mirror;

  // axis state
  int   pan_pos, tilt_pos, pan_goal, tilt_goal;
  logic pan_first;

  servo_pose_t expected_poses[$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // limit register as seen by the clamp, held to full scale
  function automatic int held_limit(input logic [AngleW-1:0] r);
    return (r > FullScale) ? int'(FullScale) : int'(r);
  endfunction

  // low bound is tested first, so min above max gives min or max
  function automatic int clamp_int(input int x, input int lo, input int hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [AngleW-1:0] drive_angle(input int angle, input logic mirror);
    int d;
    d = mirror ? (int'(FullScale) - angle) : angle;
    return d[AngleW-1:0];
  endfunction

  // apply one input word to the axis state and build the resulting pose
  task automatic advance_servo(input logic [CmdW-1:0] cmd, input logic [9:0] raw,
                               output servo_pose_t pose);
    int   val, s, np, nt;
    logic pan_need, tilt_need, pmoved, tmoved;
    val    = int'($signed(raw));
    s      = int'(slew_reg);
    pmoved = 1'b0;
    tmoved = 1'b0;
    case (cmd)
      CMD_TICK: begin
        pan_need  = (pan_pos != pan_goal);
        tilt_need = (tilt_pos != tilt_goal);
        // both pending: only one axis moves, turns alternate
        if (pan_need && tilt_need) begin
          if (pan_first) tilt_need = 1'b0;
          else pan_need = 1'b0;
          pan_first = !pan_first;
        end
        if (pan_need) begin
          np      = pan_pos + clamp_int(pan_goal - pan_pos, -s, s);
          pmoved  = (np != pan_pos);
          pan_pos = np;
        end
        if (tilt_need) begin
          nt       = tilt_pos + clamp_int(tilt_goal - tilt_pos, -s, s);
          tmoved   = (nt != tilt_pos);
          tilt_pos = nt;
        end
      end
      CMD_PAN_REL:
        pan_goal = clamp_int(pan_goal + val, held_limit(pan_lo_reg), held_limit(pan_hi_reg));
      CMD_TILT_REL:
        tilt_goal = clamp_int(tilt_goal + val, held_limit(tilt_lo_reg),
                              held_limit(tilt_hi_reg));
      CMD_PAN_ABS:
        pan_goal = clamp_int(val, held_limit(pan_lo_reg), held_limit(pan_hi_reg));
      CMD_TILT_ABS:
        tilt_goal = clamp_int(val, held_limit(tilt_lo_reg), held_limit(tilt_hi_reg));
      default: ;  // unused codes leave the state alone
    endcase
    pose.pan_angle  = pan_pos[AngleW-1:0];
    pose.tilt_angle = tilt_pos[AngleW-1:0];
    pose.pan_drive  = drive_angle(pan_pos, pan_mirror);
    pose.tilt_drive = drive_angle(tilt_pos, tilt_mirror);
    pose.pan_goal   = pan_goal[AngleW-1:0];
    pose.tilt_goal  = tilt_goal[AngleW-1:0];
    pose.pan_moved  = pmoved;
    pose.tilt_moved = tmoved;
  endtask

  task automatic check_field(input string name, input logic [AngleW-1:0] want,
                             input logic [AngleW-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_pose(input servo_pose_t want, input servo_pose_t got);
    check_field("pan_angle", want.pan_angle, got.pan_angle);
    check_field("tilt_angle", want.tilt_angle, got.tilt_angle);
    check_field("pan_drive", want.pan_drive, got.pan_drive);
    check_field("tilt_drive", want.tilt_drive, got.tilt_drive);
    check_field("pan_goal", want.pan_goal, got.pan_goal);
    check_field("tilt_goal", want.tilt_goal, got.tilt_goal);
    check_field("pan_moved", AngleW'(want.pan_moved), AngleW'(got.pan_moved));
    check_field("tilt_moved", AngleW'(want.tilt_moved), AngleW'(got.tilt_moved));
  endtask

  // sample writes and both streams at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    servo_pose_t want, got;
    if (!rst_ni) begin
      pan_lo_reg  = '0;
      pan_hi_reg  = FullScale;
      tilt_lo_reg = '0;
      tilt_hi_reg = FullScale;
      slew_reg    = AngleW'(2);
      pan_mirror  = 1'b0;
      tilt_mirror = 1'b0;
      pan_pos     = int'(CenterAngle);
      tilt_pos    = int'(CenterAngle);
      pan_goal    = int'(CenterAngle);
      tilt_goal   = int'(CenterAngle);
      pan_first   = 1'b1;
      expected_poses.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAN_MIN:     pan_lo_reg  = cfg_data_i;
          REG_PAN_MAX:     pan_hi_reg  = cfg_data_i;
          REG_TILT_MIN:    tilt_lo_reg = cfg_data_i;
          REG_TILT_MAX:    tilt_hi_reg = cfg_data_i;
          REG_SLEW_STEP:   slew_reg    = cfg_data_i;
          REG_PAN_INVERT:  pan_mirror  = cfg_data_i[0];
          REG_TILT_INVERT: tilt_mirror = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_servo(s_axis_tuser, s_axis_tdata[9:0], want);
        expected_poses.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = servo_pose_t'(m_axis_tdata[49:0]);
        if (expected_poses.size() == 0) begin
          error_count++;
          $display("%0t: result word with no pending pose, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          compare_pose(expected_poses.pop_front(), got);
        end
      end
    end
    pending_count = expected_poses.size();
  end

endmodule

// ===== bench/two_axis_servo_slew_limiter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_axis_servo_slew_limiter_core_tb
// Drives commands, ticks and register settings into the servo slew limiter
// with random gaps and back-pressure; a checker beside the block predicts and
// compares every result word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module two_axis_servo_slew_limiter_core_tb;
  import sslim_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int RandomPhases = 10;
  localparam int PhaseWords   = 172;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [AngleW-1:0]  cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // value[9:0], zero fill
  logic [CmdW-1:0]    s_axis_tuser;   // command[2:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  // pan_angle, tilt_angle, pan_drive, tilt_drive, pan_goal, tilt_goal,
  // pan_moved, tilt_moved, zero fill
  logic [55:0]        m_axis_tdata;

  int   error_count, pending_count;
  logic gaps_on = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  two_axis_servo_slew_limiter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  servo_slew_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #5 clk_i = ~clk_i;

  // mostly short idle stretches, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 99) < 25) begin
      m_axis_tready = 1'b0;
      stall_left    = idle_length() - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // present one input word, called and left at a falling edge
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [9:0] raw);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_length() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, raw};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_value(input logic [CmdW-1:0] cmd, input int val);
    send_word(cmd, val[9:0]);
  endtask

  // hold the sender until every pending pose has come back
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data[AngleW-1:0];
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // pick a limit pair: full range, equal, crossed, above full scale or plain
  task automatic random_limits(input reg_idx_e lo_idx, input reg_idx_e hi_idx);
    int r, lo, hi;
    r = $urandom_range(0, 9);
    case (r)
      0: begin lo = 0; hi = int'(FullScale); end
      1: begin lo = $urandom_range(0, 180); hi = lo; end
      2: begin hi = $urandom_range(0, 150); lo = $urandom_range(hi + 1, 180); end
      3: begin lo = $urandom_range(0, 255); hi = $urandom_range(181, 255); end
      default: begin lo = $urandom_range(0, 150); hi = $urandom_range(lo, 180); end
    endcase
    write_reg(lo_idx, lo);
    write_reg(hi_idx, hi);
  endtask

  task automatic random_settings();
    int r, step;
    random_limits(REG_PAN_MIN, REG_PAN_MAX);
    random_limits(REG_TILT_MIN, REG_TILT_MAX);
    r = $urandom_range(0, 11);
    case (r)
      0: step = 0;
      1: step = 180;
      2: step = 255;
      3: step = 1;
      default: step = $urandom_range(1, 12);
    endcase
    write_reg(REG_SLEW_STEP, step);
    write_reg(REG_PAN_INVERT, $urandom_range(0, 255));
    write_reg(REG_TILT_INVERT, $urandom_range(0, 255));
  endtask

  // mostly ticks and in-range targets, some full-range values and unused codes
  task automatic random_item();
    int   r;
    logic pan_axis;
    logic [9:0] raw;
    r        = $urandom_range(0, 99);
    pan_axis = $urandom_range(0, 1);
    if (r < 45) begin
      send_word(CMD_TICK, 10'($urandom_range(0, 1023)));
    end else if (r < 65) begin
      raw = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(0, 220) - 20);
      send_word(pan_axis ? CMD_PAN_ABS : CMD_TILT_ABS, raw);
    end else if (r < 96) begin
      raw = ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(0, 80) - 40);
      send_word(pan_axis ? CMD_PAN_REL : CMD_TILT_REL, raw);
    end else begin
      send_word(CmdW'($urandom_range(int'(CMD_TILT_ABS) + 1, (1 << CmdW) - 1)),
                10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    int phase, n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PAN_MIN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset settings, tick at rest, alternation, saturating values
    send_value(CMD_TICK, 0);
    send_value(CMD_PAN_ABS, 100);
    send_value(CMD_TILT_ABS, 80);
    repeat (4) send_value(CMD_TICK, -1);
    send_value(CMD_PAN_REL, 511);
    send_value(CMD_PAN_REL, -512);
    send_value(CMD_TILT_ABS, -512);
    send_value(CMD_TILT_ABS, 511);
    send_value(CMD_TILT_REL, 0);
    send_value(CmdW'(int'(CMD_TILT_ABS) + 1), 33);
    send_value(CmdW'((1 << CmdW) - 1), -1);
    repeat (2) send_value(CMD_TICK, 0);
    drain();

    // directed: limits above full scale, min above max, zero step, mirrored
    write_reg(REG_PAN_MIN, 200);
    write_reg(REG_PAN_MAX, 255);
    write_reg(REG_TILT_MIN, 120);
    write_reg(REG_TILT_MAX, 60);
    write_reg(REG_SLEW_STEP, 0);
    write_reg(REG_PAN_INVERT, 1);
    write_reg(REG_TILT_INVERT, 8'hff);
    send_value(CMD_PAN_ABS, 10);
    send_value(CMD_TILT_ABS, 100);
    send_value(CMD_TILT_ABS, 130);
    repeat (2) send_value(CMD_TICK, 0);
    drain();
    write_reg(REG_SLEW_STEP, 180);
    repeat (3) send_value(CMD_TICK, 0);
    drain();

    // random phases, each under fresh settings
    for (phase = 0; phase < RandomPhases; phase++) begin
      random_settings();
      gaps_on = ($urandom_range(0, 3) != 0);
      for (n = 0; n < PhaseWords; n++) random_item();
      drain();
    end

    gaps_on = 1'b0;
    repeat (10) @(negedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
